// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VAL_W   = 32;
    localparam int SUM_W   = 36;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_CMP,
        S_RD0,
        S_RD1,
        S_RD2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] popped_value;
        t_status                 status;
        logic [CNT_W-1:0]        entry_count;
        logic signed [SUM_W-1:0] sum_of_entries;
        logic signed [VAL_W-1:0] smallest_value;
        logic signed [VAL_W-1:0] largest_value;
    } t_result;

endpackage

// File: src/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded max-priority queue of signed 32-bit values with summary results.
// ----------------------------------------------------------------------------
// Each command item yields one result item. Entries sit in one single-port-
// read memory, sorted in descending order inside a circular window. An insert
// scans from the tail one entry per cycle, shifting smaller entries down. The
// memory gives one read per cycle; after an insert, or a remove that leaves
// entries, two reads refresh the cached largest and smallest entries. A
// dropped insert or a remove on an empty queue skips the refresh. A finished
// result waits in an output register, so the next item is accepted while it
// waits.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [VAL_W-1:0] o_popped_value,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic signed [SUM_W-1:0] o_sum_of_entries,
    output logic signed [VAL_W-1:0] o_smallest_value,
    output logic signed [VAL_W-1:0] o_largest_value
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                    we;
    logic [AW-1:0]           waddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic signed [VAL_W-1:0] rdata;

    logic    res_valid;
    logic    res_ready;
    t_result res;

    logic    r_valid;
    t_result r_res;

    spq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    spq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // load the output register when it is empty or being drained
    assign res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_ready) begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid          = r_valid;
    assign o_popped_value   = r_res.popped_value;
    assign o_status         = r_res.status;
    assign o_entry_count    = r_res.entry_count;
    assign o_sum_of_entries = r_res.sum_of_entries;
    assign o_smallest_value = r_res.smallest_value;
    assign o_largest_value  = r_res.largest_value;

endmodule

// File: src/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_ram
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: ordered insert by tail scan, pop from the head of a
// circular window, and refresh of the cached largest and smallest entries.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic signed [VAL_W-1:0] o_wdata,
    output logic                    o_re,
    output logic [AW-1:0]           o_raddr,
    input  logic signed [VAL_W-1:0] i_rdata
);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_head;
    logic [AW-1:0]           r_pos;
    logic signed [VAL_W-1:0] r_val;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_largest;
    logic signed [VAL_W-1:0] r_smallest;
    logic signed [VAL_W-1:0] r_popped;
    t_status                 r_status;

    logic accept;
    logic full;
    logic empty;
    logic lt;

    // map a logical slot to its physical address in the circular window
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW:0]   off);
        logic [AW+1:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= (AW+2)'(DEPTH)) begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign accept = i_valid && o_ready;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign lt     = (i_rdata < r_val);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_INSERT) begin
                        n_state = full ? S_OUT : S_INS;
                    end else begin
                        n_state = empty ? S_OUT : S_RD0;
                    end
                end
            end
            S_INS:   n_state = (r_pos == '0) ? S_RD0 : S_CMP;
            S_CMP: begin
                if (lt && (r_pos > AW'(1))) begin
                    n_state = S_CMP;
                end else if (lt) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0:   n_state = empty ? S_OUT : S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_OUT;
            S_OUT:   n_state = i_res_ready ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        o_we    = 1'b0;
        o_waddr = f_phys(r_head, {1'b0, r_pos});
        o_wdata = r_val;
        o_re    = 1'b0;
        o_raddr = f_phys(r_head, '0);
        case (r_state)
            S_INS: begin
                if (r_pos == '0) begin
                    o_we = 1'b1;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = f_phys(r_head, {1'b0, r_pos} - (AW+1)'(1));
                end
            end
            S_CMP: begin
                o_we = 1'b1;
                if (lt) begin
                    // shift the smaller entry one slot toward the tail
                    o_wdata = i_rdata;
                    if (r_pos > AW'(1)) begin
                        o_re    = 1'b1;
                        o_raddr = f_phys(r_head, {1'b0, r_pos} - (AW+1)'(2));
                    end
                end
            end
            S_RD0: begin
                o_re = !empty;
            end
            S_RD1: begin
                o_re    = 1'b1;
                o_raddr = f_phys(r_head, (AW+1)'(r_count) - (AW+1)'(1));
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);

    always_comb begin
        o_res.popped_value = r_popped;
        o_res.status       = r_status;
        o_res.entry_count  = CNT_W'(r_count);
        if (empty) begin
            o_res.sum_of_entries = '0;
            o_res.smallest_value = '0;
            o_res.largest_value  = '0;
        end else begin
            o_res.sum_of_entries = r_sum;
            o_res.smallest_value = r_smallest;
            o_res.largest_value  = r_largest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= ST_DONE;
                        r_popped <= '0;
                        r_val    <= i_value;
                        r_pos    <= r_count[AW-1:0];
                        if (i_cmd == CMD_INSERT) begin
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + CW'(1);
                                r_sum   <= r_sum + SUM_W'(i_value);
                            end
                        end else begin
                            if (empty) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                // the cached largest entry is the head
                                r_popped <= r_largest;
                                r_head   <= f_phys(r_head, (AW+1)'(1));
                                r_count  <= r_count - CW'(1);
                                r_sum    <= r_sum - SUM_W'(r_largest);
                            end
                        end
                    end
                end
                S_CMP: begin
                    if (lt) begin
                        r_pos <= r_pos - AW'(1);
                    end
                end
                S_RD1: r_largest  <= i_rdata;
                S_RD2: r_smallest <= i_rdata;
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < (AW+1)'(DEPTH))
        else $error("head pointer out of range");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> r_pos != '0)
        else $error("scan reached slot zero in compare state");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd == CMD_INSERT && !full |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not raise count");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd == CMD_REMOVE && !empty |=> r_count == $past(r_count) - CW'(1))
        else $error("remove did not lower count");

endmodule
